### sv/ttld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trigger toggle latch package
// Shared codes, reset values and payload types for the trigger latch block.
// ----------------------------------------------------------------------------
package ttld_pkg;

  // Opcodes of a request; the fourth code is unused and changes nothing
  localparam logic [1:0] OP_CMD   = 2'd0;
  localparam logic [1:0] OP_SYNC  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  // Gripper states
  localparam logic [1:0] ST_OPEN  = 2'd0;
  localparam logic [1:0] ST_CLOSE = 2'd1;
  localparam logic [1:0] ST_HOLD  = 2'd2;
  localparam logic [1:0] ST_FAULT = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_ANALOG_MODE = 2'd0;
  localparam logic [1:0] REG_OPEN_LEVEL  = 2'd1;
  localparam logic [1:0] REG_CLOSE_LEVEL = 2'd2;
  localparam logic [1:0] REG_DEBOUNCE_NS = 2'd3;

  // Q2.14 levels
  localparam logic [14:0]        ONE_Q14      = 15'd16384;
  localparam logic [14:0]        HALF_Q14     = 15'd8192;
  localparam logic signed [15:0] ONE_Q14_S    = 16'sd16384;

  // Configuration reset values
  localparam logic        RST_ANALOG_MODE = 1'b0;
  localparam logic [14:0] RST_OPEN_LEVEL  = 15'd4096;
  localparam logic [14:0] RST_CLOSE_LEVEL = 15'd12288;
  localparam logic [31:0] RST_DEBOUNCE_NS = 32'd200000000;

  typedef struct packed {
    logic        analog_mode;
    logic [14:0] open_level;
    logic [14:0] close_level;
    logic [31:0] debounce_ns;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic signed [15:0] command_level;
    logic [63:0]       time_ns;
    logic [1:0]        given_state;
  } item_t;

endpackage

### sv/ttld_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trigger toggle latch channels
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface ttld_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [15:0] command_level;
  logic [63:0]        time_ns;
  logic [1:0]         given_state;

  modport source (
    output valid, opcode, command_level, time_ns, given_state,
    input  ready
  );
  modport sink (
    input  valid, opcode, command_level, time_ns, given_state,
    output ready
  );
endinterface

interface ttld_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] gripper_state;

  modport source (
    output valid, gripper_state,
    input  ready
  );
  modport sink (
    input  valid, gripper_state,
    output ready
  );
endinterface

### sv/trigger_toggle_latch_debounce_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trigger toggle latch with debounce
// Turns a Q2.14 trigger level into a gripper open/close state, in analog
// threshold mode or in toggle mode with a rearm latch and a debounce time.
// ----------------------------------------------------------------------------
//
//  Channel | Role   | Payload                                        | Per request
//  --------+--------+------------------------------------------------+------------
//  req     | sink   | opcode, command_level, time_ns, given_state    | one in
//  res     | source | gripper_state                                  | one out
//  cfg     | write  | cfg_we, cfg_index, cfg_data (32 bits)          | -
//
//  One request per cycle sustained while results are taken; an accepted
//  request passes the input register, then the result register, before
//  its result shows.
//  The critical path is the 64-bit elapsed-time subtract and compare against
//  debounce_ns, plus the next-state selection.
//  Reset (rst, synchronous) clears the channel valid bits, the latch state
//  and loads the configuration defaults.
//  A stalled result holds in its register; the input register still takes a
//  new request when the result is taken in the same cycle.
//
module trigger_toggle_latch_debounce_unit import ttld_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  ttld_req_if.sink    req,
  ttld_res_if.source  res
);

  cfg_t       cfg;
  item_t      item_q;
  logic       item_valid;
  logic       res_valid;
  logic [1:0] res_state;
  logic       advance;
  logic [1:0] state_next;
  logic [1:0] held_state;

  // Configuration registers: the user must write them only while idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.analog_mode <= RST_ANALOG_MODE;
      cfg.open_level  <= RST_OPEN_LEVEL;
      cfg.close_level <= RST_CLOSE_LEVEL;
      cfg.debounce_ns <= RST_DEBOUNCE_NS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ANALOG_MODE: cfg.analog_mode <= cfg_data[0];
        REG_OPEN_LEVEL:  cfg.open_level  <= cfg_data[14:0];
        REG_CLOSE_LEVEL: cfg.close_level <= cfg_data[14:0];
        REG_DEBOUNCE_NS: cfg.debounce_ns <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Advance the held request into the result register when that is free or being taken
  assign advance   = item_valid && (!res_valid || res.ready);
  assign req.ready = !item_valid || advance;

  // Input register: capture a request whenever the slot is free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      item_q.opcode        <= req.opcode;
      item_q.command_level <= req.command_level;
      item_q.time_ns       <= req.time_ns;
      item_q.given_state   <= req.given_state;
    end
  end

  // State update and next-state logic
  ttld_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fire       (advance),
    .item       (item_q),
    .state_next (state_next),
    .held_state (held_state)
  );

  // Result register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_state <= state_next;
    end
  end

  assign res.valid         = res_valid;
  assign res.gripper_state = res_state;

  // A reset request loads the given state, whatever its code
  assert property (@(posedge clk) disable iff (rst)
    advance && item_q.opcode == OP_RESET |=> res_state == $past(item_q.given_state))
    else $error("reset request did not load the given state");

  // Analog mode only ever yields open or close for a command
  assert property (@(posedge clk) disable iff (rst)
    advance && item_q.opcode == OP_CMD && cfg.analog_mode
      |=> res_state == ST_OPEN || res_state == ST_CLOSE)
    else $error("analog command produced a state other than open or close");

  // A sync carrying fault leaves the held state alone
  assert property (@(posedge clk) disable iff (rst)
    advance && item_q.opcode == OP_SYNC && item_q.given_state == ST_FAULT
      |=> held_state == $past(held_state) && res_state == held_state)
    else $error("fault sync changed the held state");

  // The shown result always matches the held state once issued
  assert property (@(posedge clk) disable iff (rst)
    advance |=> res_state == held_state)
    else $error("result register and held state disagree");

endmodule

### sv/ttld_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trigger toggle latch core
// Holds the gripper state, press latch and toggle time; computes the next
// state for one request.
// ----------------------------------------------------------------------------
module ttld_core import ttld_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       fire,
  input  item_t      item,
  output logic [1:0] state_next,
  output logic [1:0] held_state
);

  logic        trigger_latched;
  logic        trigger_latched_next;
  logic [63:0] last_toggle_ns;
  logic [63:0] last_toggle_ns_next;
  logic        toggle_seen;
  logic        toggle_seen_next;

  logic [14:0] cmd;
  logic [15:0] cmd_x2;
  logic [15:0] level_sum;
  logic        rearm;
  logic [63:0] elapsed;
  logic        debounce_ok;

  // Clamp the level to 0..1.0
  assign cmd = item.command_level[15]          ? '0 :
               (item.command_level > ONE_Q14_S) ? ONE_Q14 :
               item.command_level[14:0];

  // Rearm at or below min(midpoint, close), midpoint kept exact
  assign cmd_x2    = {cmd, 1'b0};
  assign level_sum = {1'b0, cfg.open_level} + {1'b0, cfg.close_level};
  assign rearm     = (cmd_x2 <= level_sum) && (cmd <= cfg.close_level);

  assign elapsed     = item.time_ns - last_toggle_ns;
  assign debounce_ok = !toggle_seen || (elapsed >= {32'd0, cfg.debounce_ns});

  always_comb begin
    state_next           = held_state;
    trigger_latched_next = trigger_latched;
    last_toggle_ns_next  = last_toggle_ns;
    toggle_seen_next     = toggle_seen;
    case (item.opcode)
      OP_CMD: begin
        if (cfg.analog_mode) begin
          state_next = (cmd >= HALF_Q14) ? ST_CLOSE : ST_OPEN;
        end else begin
          trigger_latched_next = trigger_latched && !rearm;
          if (cmd >= cfg.close_level && !trigger_latched_next) begin
            if (debounce_ok) begin
              state_next          = (held_state == ST_CLOSE || held_state == ST_HOLD) ?
                                    ST_OPEN : ST_CLOSE;
              last_toggle_ns_next = item.time_ns;
              toggle_seen_next    = 1'b1;
            end
            trigger_latched_next = 1'b1;
          end
        end
      end
      OP_SYNC: begin
        if (item.given_state != ST_FAULT) begin
          state_next = (item.given_state == ST_CLOSE || item.given_state == ST_HOLD) ?
                       ST_CLOSE : ST_OPEN;
        end
      end
      OP_RESET: begin
        state_next           = item.given_state;
        trigger_latched_next = 1'b0;
        last_toggle_ns_next  = '0;
        toggle_seen_next     = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_state      <= ST_OPEN;
      trigger_latched <= 1'b0;
      last_toggle_ns  <= '0;
      toggle_seen     <= 1'b0;
    end else if (fire) begin
      held_state      <= state_next;
      trigger_latched <= trigger_latched_next;
      last_toggle_ns  <= last_toggle_ns_next;
      toggle_seen     <= toggle_seen_next;
    end
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trigger toggle latch testbench
// Drives requests into the trigger latch block and checks every gripper
// state it returns against a cycle-free model of the latch, rearm and
// debounce rules kept inside this bench. Directed tests cover the clamp,
// the rearm threshold, debounce with time wrap, sync, reset and analog
// requests. Random phases then run under several register settings,
// extremes included, most with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import ttld_pkg::*;

  // Fourth opcode: the block leaves its state alone
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT = 200000;
  localparam int GAP_PERCENT = 8;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  ttld_req_if req_ch ();
  ttld_res_if res_ch ();

  trigger_toggle_latch_debounce_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Latch model: register copies and state, advanced once per accepted
  // request in acceptance order.
  // --------------------------------------------------------------------------
  logic        mode_analog;
  logic [14:0] lvl_open;
  logic [14:0] lvl_close;
  logic [31:0] debounce_limit;

  logic [1:0]  held_gripper;
  logic        press_latched;
  logic [63:0] last_toggle_ns;
  logic        toggle_seen;

  // Gripper states the block is expected to return, oldest first
  logic [1:0]  expected_states[$];

  bit          gaps_on;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  logic [63:0] stim_time_ns;

  function automatic void reset_latch_model();
    mode_analog    = RST_ANALOG_MODE;
    lvl_open       = RST_OPEN_LEVEL;
    lvl_close      = RST_CLOSE_LEVEL;
    debounce_limit = RST_DEBOUNCE_NS;
    held_gripper   = ST_OPEN;
    press_latched  = 1'b0;
    last_toggle_ns = '0;
    toggle_seen    = 1'b0;
  endfunction

  // Advance the model by one request and return the state it leaves behind
  function automatic logic [1:0] advance_gripper(input item_t it);
    int          raw;
    int          cmd;
    int          open_i;
    int          close_i;
    logic [63:0] elapsed;
    raw     = $signed(it.command_level);
    open_i  = lvl_open;
    close_i = lvl_close;
    case (it.opcode)
      OP_CMD: begin
        // clamp to 0..1.0 in Q2.14
        if (raw < 0) cmd = 0;
        else if (raw > ONE_Q14) cmd = ONE_Q14;
        else cmd = raw;
        if (mode_analog) begin
          held_gripper = (cmd >= HALF_Q14) ? ST_CLOSE : ST_OPEN;
        end else begin
          // rearm at or below the midpoint, never above the close level
          if (2 * cmd <= open_i + close_i && cmd <= close_i) press_latched = 1'b0;
          if (cmd >= close_i && !press_latched) begin
            elapsed = it.time_ns - last_toggle_ns;
            if (!toggle_seen || elapsed >= {32'd0, debounce_limit}) begin
              // hold counts as closed
              held_gripper   = (held_gripper == ST_CLOSE || held_gripper == ST_HOLD) ?
                               ST_OPEN : ST_CLOSE;
              last_toggle_ns = it.time_ns;
              toggle_seen    = 1'b1;
            end
            press_latched = 1'b1;
          end
        end
      end
      OP_SYNC: begin
        // a fault reading changes nothing
        if (it.given_state != ST_FAULT) begin
          held_gripper = (it.given_state == ST_CLOSE || it.given_state == ST_HOLD) ?
                         ST_CLOSE : ST_OPEN;
        end
      end
      OP_RESET: begin
        held_gripper   = it.given_state;
        press_latched  = 1'b0;
        last_toggle_ns = '0;
        toggle_seen    = 1'b0;
      end
      default: ;
    endcase
    return held_gripper;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [1:0] op, input logic signed [15:0] lvl,
                              input logic [63:0] t_ns, input logic [1:0] given);
    item_t it;
    it.opcode        = op;
    it.command_level = lvl;
    it.time_ns       = t_ns;
    it.given_state   = given;
    // idle the channel now and then
    if (gaps_on) begin
      while ($urandom_range(0, 99) < GAP_PERCENT) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= op;
    req_ch.command_level <= lvl;
    req_ch.time_ns       <= t_ns;
    req_ch.given_state   <= given;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_states.push_back(advance_gripper(it));
  endtask

  // Drop valid and hold until every expected state has come back
  task automatic settle_idle();
    req_ch.valid <= 1'b0;
    while (expected_states.size() != 0) @(posedge clk);
  endtask

  // Write all four registers back to back; only while the block is idle
  task automatic load_config(input logic analog, input logic [14:0] open_l,
                             input logic [14:0] close_l, input logic [31:0] deb);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ANALOG_MODE;
    cfg_data  <= {31'd0, analog};
    @(posedge clk);
    cfg_index <= REG_OPEN_LEVEL;
    cfg_data  <= {17'd0, open_l};
    @(posedge clk);
    cfg_index <= REG_CLOSE_LEVEL;
    cfg_data  <= {17'd0, close_l};
    @(posedge clk);
    cfg_index <= REG_DEBOUNCE_NS;
    cfg_data  <= deb;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_analog    = analog;
    lvl_open       = open_l;
    lvl_close      = close_l;
    debounce_limit = deb;
  endtask

  // Levels clustered around the thresholds that matter, plus full-range noise
  function automatic logic signed [15:0] pick_level();
    int mid;
    int v;
    mid = (int'(lvl_open) + int'(lvl_close)) / 2;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 65535);
      1: v = int'(lvl_close) + int'($urandom_range(0, 4)) - 2;
      2: v = mid + int'($urandom_range(0, 4)) - 2;
      3: v = int'(HALF_Q14) + int'($urandom_range(0, 4)) - 2;
      4: v = $urandom_range(0, (mid > 0) ? mid : 0);
      5: v = $urandom_range(lvl_close, ONE_Q14);
      6: begin
        case ($urandom_range(0, 5))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          3: v = ONE_Q14;
          4: v = ONE_Q14 + 1;
          default: v = -1;
        endcase
      end
      default: v = $urandom_range(0, ONE_Q14);
    endcase
    return v[15:0];
  endfunction

  // Time steps around the debounce window, with rare jumps anywhere
  function automatic logic [63:0] pick_step();
    case ($urandom_range(0, 9))
      0, 1, 2: return 64'($urandom_range(0, 1000));
      3, 4, 5: return {32'd0, debounce_limit} + 64'($urandom_range(0, 6)) - 64'd3;
      6:       return 64'($urandom_range(0, debounce_limit));
      7:       return {$urandom, $urandom};
      8:       return 64'd0;
      default: return 64'($urandom);
    endcase
  endfunction

  task automatic run_phase(input logic analog, input logic [14:0] open_l,
                           input logic [14:0] close_l, input logic [31:0] deb,
                           input bit with_gaps, input int n_items);
    int          r;
    logic [1:0]  op;
    settle_idle();
    load_config(analog, open_l, close_l, deb);
    gaps_on = with_gaps;
    // start some phases close to the 64-bit wrap
    stim_time_ns = ($urandom_range(0, 3) == 0) ? {32'hFFFF_FFFF, $urandom} :
                   64'($urandom);
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 84) op = OP_CMD;
      else if (r < 91) op = OP_SYNC;
      else if (r < 96) op = OP_RESET;
      else op = OP_UNUSED;
      stim_time_ns = stim_time_ns + pick_step();
      send_request(op, pick_level(), stim_time_ns, 2'($urandom_range(0, 3)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, compare against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    res_ch.ready <= !(gaps_on && $urandom_range(0, 99) < GAP_PERCENT);
  end

  always @(posedge clk) begin : check_results
    logic [1:0] want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_states.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual gripper_state %0d",
                 $time, res_ch.gripper_state);
        mismatch_count++;
      end else begin
        want = expected_states.pop_front();
        if (res_ch.gripper_state !== want) begin
          $display("%0t: gripper_state mismatch, expected %0d, actual %0d",
                   $time, want, res_ch.gripper_state);
          mismatch_count++;
        end
      end
    end
  end

  // Hard stop if the handshakes hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Default registers: clamp, rearm midpoint, debounce and its 64-bit wrap
  task automatic test_toggle_press();
    gaps_on = 1'b1;
    send_request(OP_CMD, 16'sd12288, 64'd1000, ST_OPEN);        // first press always toggles
    send_request(OP_CMD, 16'sd12288, 64'd2000, ST_OPEN);        // still latched
    send_request(OP_CMD, 16'sd8192, 64'd3000, ST_OPEN);         // exactly at rearm
    send_request(OP_CMD, 16'sd16384, 64'd4000, ST_OPEN);        // too soon, latch only
    send_request(OP_CMD, -16'sd32768, 64'd5000, ST_OPEN);       // clamps to zero
    send_request(OP_CMD, 16'sd32767, 64'd200_001_000, ST_OPEN); // exactly the debounce
    send_request(OP_CMD, 16'sd8193, 64'd200_002_000, ST_OPEN);  // just above rearm
    send_request(OP_CMD, 16'sd12287, 64'd400_000_000, ST_OPEN); // just below press
    send_request(OP_RESET, 16'sd0, 64'd0, ST_OPEN);
    send_request(OP_CMD, 16'sd12288, 64'hFFFF_FFFF_FFFF_FC18, ST_OPEN);
    send_request(OP_CMD, 16'sd0, 64'd0, ST_OPEN);
    // elapsed wraps through zero to exactly the debounce
    send_request(OP_CMD, 16'sd12288, 64'd199_999_000, ST_OPEN);
    send_request(OP_CMD, 16'sd0, 64'd199_999_000, ST_OPEN);
    send_request(OP_CMD, 16'sd16384, 64'd199_999_001, ST_OPEN);
  endtask

  // Sync readings, reset requests to hold and fault, the unused opcode
  task automatic test_sync_and_reset();
    send_request(OP_SYNC, 16'sd0, 64'd0, ST_FAULT);              // ignored
    send_request(OP_SYNC, 16'sd0, 64'd0, ST_HOLD);               // hold reads as close
    send_request(OP_SYNC, 16'sd0, 64'd0, ST_OPEN);
    send_request(OP_SYNC, 16'sd0, 64'd0, ST_CLOSE);
    send_request(OP_RESET, 16'sd0, 64'd0, ST_HOLD);
    send_request(OP_CMD, 16'sd16384, 64'd0, ST_OPEN);            // toggle from hold opens
    send_request(OP_RESET, 16'sd0, 64'd0, ST_FAULT);
    send_request(OP_CMD, 16'sd16384, 64'd7, ST_OPEN);            // toggle from fault closes
    send_request(OP_UNUSED, -16'sd1, 64'hFFFF_FFFF_FFFF_FFFF, ST_FAULT);
  endtask

  // Analog mode: one half is the only threshold
  task automatic test_analog_mode();
    settle_idle();
    load_config(1'b1, RST_OPEN_LEVEL, RST_CLOSE_LEVEL, RST_DEBOUNCE_NS);
    send_request(OP_CMD, 16'sd8191, 64'd10, ST_OPEN);
    send_request(OP_CMD, 16'sd8192, 64'd20, ST_OPEN);
    send_request(OP_CMD, -16'sd1, 64'd30, ST_OPEN);
    send_request(OP_CMD, 16'sd32767, 64'd40, ST_OPEN);
    send_request(OP_CMD, 16'sd16385, 64'd50, ST_OPEN);
  endtask

  // Random traffic under fixed extremes, then random settings
  task automatic test_random_phases();
    logic [31:0] deb;
    run_phase(1'b0, RST_OPEN_LEVEL, RST_CLOSE_LEVEL, RST_DEBOUNCE_NS, 1'b1, 150);
    run_phase(1'b0, 15'd0, 15'd0, 32'd0, 1'b1, 150);
    // long stretch with no idling on either side
    run_phase(1'b0, ONE_Q14, ONE_Q14, 32'hFFFF_FFFF, 1'b0, 300);
    // open above close: rearm clamps to the close level
    run_phase(1'b0, ONE_Q14, 15'd4096, 32'd1000, 1'b1, 150);
    run_phase(1'b0, 15'd0, ONE_Q14, 32'd500, 1'b1, 150);
    // close level beyond 1.0 is never reached
    run_phase(1'b0, 15'd8000, 15'd20000, 32'd100, 1'b1, 100);
    run_phase(1'b1, 15'd0, ONE_Q14, 32'd0, 1'b1, 150);
    repeat (4) begin
      deb = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 5000)) : $urandom;
      run_phase($urandom_range(0, 3) == 0, 15'($urandom_range(0, ONE_Q14)),
                15'($urandom_range(0, ONE_Q14)), deb, 1'b1, 150);
    end
  endtask

  initial begin
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= REG_ANALOG_MODE;
    cfg_data             <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.opcode        <= OP_CMD;
    req_ch.command_level <= '0;
    req_ch.time_ns       <= '0;
    req_ch.given_state   <= ST_OPEN;
    gaps_on        = 1'b0;
    stim_time_ns   = '0;
    reset_latch_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_toggle_press();
    test_sync_and_reset();
    test_analog_mode();
    test_random_phases();

    // drain, then let the two-stage pipe show any strays
    settle_idle();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
